[design/outlier_rejecting_sample_average_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the outlier rejecting sample averager
// Shared property wrappers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef OUTLIER_REJECTING_SAMPLE_AVERAGE_CORE_ASSERT_SVH
`define OUTLIER_REJECTING_SAMPLE_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication
`define ORSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ORSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/orsa_pkg.sv]
// ---------------------------------------------------------------------------
// orsa_pkg
// Shared types and constants of the outlier rejecting sample averager.
// ---------------------------------------------------------------------------
package orsa_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int DEV_W       = 24;
  localparam int FAIL_W      = 8;
  localparam int STATUS_W    = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVIATION_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FAILURE_LIMIT   = 2'd2;

  // Register reset values
  localparam int                SAMPLE_COUNT_RST    = 16;
  localparam logic [DEV_W-1:0]  DEVIATION_LIMIT_RST = 24'd300000;
  localparam logic [FAIL_W-1:0] FAILURE_LIMIT_RST   = 8'd10;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAILURES = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic div_run;   // divider steps this cycle
    logic out_load;  // result register loads this cycle
  } orsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_now;  // current word ends the run with an immediate result
    logic start_div; // current word ends the run and needs a division
    logic div_last;  // divider is on its final step
  } orsa_stat_t;

endpackage

[design/orsa_ctrl.sv]
// ---------------------------------------------------------------------------
// orsa_ctrl
// Controller: input/output handshake, divide sequencing, result valid.
// ---------------------------------------------------------------------------
`include "outlier_rejecting_sample_average_core_assert.svh"

module orsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output orsa_pkg::orsa_cmd_t cmd,
  input  orsa_pkg::orsa_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  // Take a word when idle and the result slot is free or draining
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  assign cmd.accept   = accept;
  assign cmd.div_run  = (state_r == S_DIV);
  assign cmd.out_load = (accept && stat.emit_now) || ((state_r == S_DIV) && stat.div_last);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && stat.start_div) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.div_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ORSA_ASSERT_NXT(a_start_enters_div, accept && stat.start_div, state_r == S_DIV,
                   "run completion did not start the divider")
  `ORSA_ASSERT_IMP(a_div_slot_empty, state_r == S_DIV, !out_valid_r,
                   "result register occupied while dividing")
  `ORSA_ASSERT_NXT(a_div_end_result, (state_r == S_DIV) && stat.div_last,
                   out_valid_r && (state_r == S_IDLE),
                   "divider end did not deliver a result")

endmodule

[design/orsa_datapath.sv]
// ---------------------------------------------------------------------------
// orsa_datapath
// Config registers, sample checks, run state, serial divider, result word.
// ---------------------------------------------------------------------------
module orsa_datapath #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [orsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [orsa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [SAMPLE_WIDTH-1:0]              sample,
  input  logic                                 timed_out,
  input  orsa_pkg::orsa_cmd_t                  cmd,
  output orsa_pkg::orsa_stat_t                 stat,
  output logic [SAMPLE_WIDTH-1:0]              average,
  output logic [orsa_pkg::STATUS_W-1:0]        status
);

  localparam int SUM_W   = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int CNT_W   = COUNT_WIDTH + 1;
  localparam int CMP_W   = (SAMPLE_WIDTH > orsa_pkg::DEV_W ? SAMPLE_WIDTH
                                                           : orsa_pkg::DEV_W) + 2;
  localparam int DCNT_W  = $clog2(SUM_W);

  // Configuration registers
  logic [COUNT_WIDTH-1:0]          scount_r;
  logic [orsa_pkg::DEV_W-1:0]      dev_r;
  logic [orsa_pkg::FAIL_W-1:0]     flim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scount_r <= COUNT_WIDTH'(orsa_pkg::SAMPLE_COUNT_RST);
      dev_r    <= orsa_pkg::DEVIATION_LIMIT_RST;
      flim_r   <= orsa_pkg::FAILURE_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        orsa_pkg::REG_SAMPLE_COUNT:    scount_r <= cfg_data[COUNT_WIDTH-1:0];
        orsa_pkg::REG_DEVIATION_LIMIT: dev_r    <= cfg_data[orsa_pkg::DEV_W-1:0];
        orsa_pkg::REG_FAILURE_LIMIT:   flim_r   <= cfg_data[orsa_pkg::FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Run state
  logic signed [SUM_W-1:0]        sum_r;
  logic        [CNT_W-1:0]        cnt_r;
  logic        [orsa_pkg::FAIL_W-1:0] fc_r;
  logic signed [SAMPLE_WIDTH-1:0] last_r;
  logic                           known_r;
  logic                           first_r;

  // Sample checks
  logic signed [SAMPLE_WIDTH-1:0] s;
  logic signed [CMP_W-1:0]        diff, dev_x;
  logic                           bad_code, too_far, fail;
  logic        [orsa_pkg::FAIL_W-1:0] fc_inc;
  logic                           fail_abort;
  logic signed [SUM_W-1:0]        sum_new;
  logic        [CNT_W-1:0]        cnt_new;
  logic                           run_done;

  assign s        = $signed(sample);
  assign diff     = CMP_W'(s) - CMP_W'(last_r);
  assign dev_x    = $signed(CMP_W'(dev_r));
  assign bad_code = (sample == '0) || (sample == '1);
  assign too_far  = known_r && ((diff > dev_x) || (diff < -dev_x));
  assign fail     = bad_code || too_far;
  assign fc_inc   = fc_r + 1'b1;
  assign fail_abort = fc_inc >= flim_r;

  // Sum and count with this word folded in (first word of a run is dropped)
  assign sum_new  = first_r ? sum_r : sum_r + SUM_W'(s);
  assign cnt_new  = first_r ? cnt_r : cnt_r + 1'b1;
  assign run_done = cnt_new >= CNT_W'(scount_r);

  assign stat.emit_now  = timed_out || (fail && fail_abort) ||
                          (!fail && run_done && (cnt_new == '0));
  assign stat.start_div = !timed_out && !fail && run_done && (cnt_new != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      fc_r    <= '0;
      last_r  <= '0;
      known_r <= 1'b0;
      first_r <= 1'b1;
    end else if (cmd.accept) begin
      if (stat.emit_now || stat.start_div) begin
        // Any result starts a fresh run
        sum_r   <= '0;
        cnt_r   <= '0;
        fc_r    <= '0;
        last_r  <= '0;
        known_r <= 1'b0;
        first_r <= 1'b1;
      end else if (fail) begin
        fc_r <= fc_inc;
      end else begin
        sum_r   <= sum_new;
        cnt_r   <= cnt_new;
        first_r <= 1'b0;
        if (!first_r) begin
          last_r  <= s;
          known_r <= 1'b1;
        end
      end
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle
  logic [SUM_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              neg_r;
  logic [SUM_W-1:0]  sum_mag;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [SUM_W-1:0]  dvd_step;
  logic [CNT_W-1:0]  rem_step;
  logic [SAMPLE_WIDTH-1:0] quot;

  assign sum_mag  = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
  assign rem_sh   = {rem_r, dvd_r[SUM_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs_r};
  assign rem_step = ge ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];
  assign dvd_step = {dvd_r[SUM_W-2:0], ge};
  assign quot     = neg_r ? -dvd_step[SAMPLE_WIDTH-1:0] : dvd_step[SAMPLE_WIDTH-1:0];
  assign stat.div_last = (dcnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.accept && stat.start_div) begin
      dvd_r  <= sum_mag;
      dvs_r  <= cnt_new;
      rem_r  <= '0;
      dcnt_r <= DCNT_W'(SUM_W - 1);
      neg_r  <= sum_new[SUM_W-1];
    end else if (cmd.div_run) begin
      dvd_r  <= dvd_step;
      rem_r  <= rem_step;
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // Result word
  logic [SAMPLE_WIDTH-1:0]       average_r;
  logic [orsa_pkg::STATUS_W-1:0] status_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.div_run) begin
        average_r <= quot;
        status_r  <= orsa_pkg::STATUS_DONE;
      end else if (timed_out) begin
        average_r <= '1;
        status_r  <= orsa_pkg::STATUS_TIMEOUT;
      end else if (fail) begin
        average_r <= '1;
        status_r  <= orsa_pkg::STATUS_FAILURES;
      end else begin
        // run of zero samples
        average_r <= '0;
        status_r  <= orsa_pkg::STATUS_DONE;
      end
    end
  end

  assign average = average_r;
  assign status  = status_r;

endmodule

[design/outlier_rejecting_sample_average_core.sv]
// ---------------------------------------------------------------------------
// outlier_rejecting_sample_average_core
// Averages converter samples per run, rejecting stuck codes and outliers.
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   tdata: sample   tuser: timed_out
//   out_     out  out_tvalid/out_tready tdata: average  tuser: status
//   cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A word that ends no run only updates the run state; an abort shows its
// result on the next cycle. A completed run with a nonzero count then
// steps through the bit-serial restoring divider.
// Reset returns registers to defaults and starts a fresh run; no sweep.
// Input is held off while dividing or while an untaken result sits in the
// output register. cfg_ready is always high.
// ---------------------------------------------------------------------------
module outlier_rejecting_sample_average_core #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    in_tdata,  // sample
  input  logic [0:0]                           in_tuser,  // timed_out
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    out_tdata, // average
  output logic [orsa_pkg::STATUS_W-1:0]        out_tuser, // status
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [orsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [orsa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  orsa_pkg::orsa_cmd_t     cmd;
  orsa_pkg::orsa_stat_t    stat;
  logic [SAMPLE_WIDTH-1:0] average;

  assign cfg_ready = 1'b1;
  assign out_tdata = TDATA_W'(average);

  orsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  orsa_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (in_tdata[SAMPLE_WIDTH-1:0]),
    .timed_out (in_tuser[0]),
    .cmd       (cmd),
    .stat      (stat),
    .average   (average),
    .status    (out_tuser)
  );

endmodule

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the outlier rejecting sample averager. A short
// directed pass covers field extremes, zero count, mid-run count change and
// every abort path; then random register settings drive mostly well-formed
// sample runs with stuck codes, outliers and timeouts mixed in. Results are
// scored in order against an in-bench model of the run state.
// ---------------------------------------------------------------------------

// One expected or observed result word
typedef struct packed {
  logic [23:0]                   average;
  logic [orsa_pkg::STATUS_W-1:0] status;
} avg_result_t;

// Run-state model and in-order result store
class avg_scoreboard;
  // register copies
  bit [15:0]                 count_reg    = 16'(orsa_pkg::SAMPLE_COUNT_RST);
  bit [orsa_pkg::DEV_W-1:0]  dev_reg      = orsa_pkg::DEVIATION_LIMIT_RST;
  bit [orsa_pkg::FAIL_W-1:0] fail_lim_reg = orsa_pkg::FAILURE_LIMIT_RST;
  // run state
  longint    run_sum;
  bit [16:0] good_cnt;
  bit [7:0]  fail_cnt;
  longint    last_good;
  bit        have_ref;
  bit        skip_first = 1'b1;
  avg_result_t due_avgs[$];
  // bookkeeping
  int n_words, n_timed_out, n_done, n_timeouts, n_overfail, n_seen, errors;

  function void restart_run();
    run_sum    = 0;
    good_cnt   = '0;
    fail_cnt   = '0;
    last_good  = 0;
    have_ref   = 1'b0;
    skip_first = 1'b1;
  endfunction

  function void queue_result(longint avg, logic [orsa_pkg::STATUS_W-1:0] st);
    avg_result_t r;
    r.average = avg[23:0];
    r.status  = st;
    due_avgs.push_back(r);
    case (st)
      orsa_pkg::STATUS_DONE:    n_done++;
      orsa_pkg::STATUS_TIMEOUT: n_timeouts++;
      default:                  n_overfail++;
    endcase
    restart_run();
  endfunction

  function void write_reg(bit [orsa_pkg::CFG_INDEX_W-1:0] idx,
                          bit [orsa_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      orsa_pkg::REG_SAMPLE_COUNT:    count_reg    = val[15:0];
      orsa_pkg::REG_DEVIATION_LIMIT: dev_reg      = val[orsa_pkg::DEV_W-1:0];
      orsa_pkg::REG_FAILURE_LIMIT:   fail_lim_reg = val[orsa_pkg::FAIL_W-1:0];
      default: ;
    endcase
  endfunction

  // Accepted input word: advance the run, queue a result if it ends
  function void note_word(bit [23:0] smp, bit tmo);
    longint s, lim, avg;
    bit     bad;
    n_words++;
    if (tmo) begin
      n_timed_out++;
      queue_result(-1, orsa_pkg::STATUS_TIMEOUT);
      return;
    end
    s   = longint'($signed(smp));
    lim = longint'(dev_reg);
    // stuck codes, then distance from the last good sample
    bad = (s == 0) || (s == -1);
    if (!bad && have_ref)
      bad = (s > last_good + lim) || (s < last_good - lim);
    if (bad) begin
      fail_cnt++;
      if (fail_cnt >= fail_lim_reg)
        queue_result(-1, orsa_pkg::STATUS_FAILURES);
      return;
    end
    if (skip_first) begin
      skip_first = 1'b0;
    end else begin
      run_sum   += s;
      good_cnt++;
      last_good = s;
      have_ref  = 1'b1;
    end
    if (good_cnt >= count_reg) begin
      avg = (good_cnt != 0) ? run_sum / longint'(good_cnt) : 0;
      queue_result(avg, orsa_pkg::STATUS_DONE);
    end
  endfunction

  // Accepted result word: compare with the oldest expectation
  function void check_result(logic [23:0] avg, logic [orsa_pkg::STATUS_W-1:0] st);
    avg_result_t want;
    n_seen++;
    if (due_avgs.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result %0d unexpected: average %0d status %0d", n_seen,
                 $signed(avg), st);
      return;
    end
    want = due_avgs.pop_front();
    if (avg !== want.average || st !== want.status) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: expected average %0d status %0d, got average %0d status %0d",
                 n_seen, $signed(want.average), want.status, $signed(avg), st);
    end
  endfunction

  function int outstanding();
    return due_avgs.size();
  endfunction
endclass

module tb_top;

  localparam int     TOTAL_WORDS    = 1850;
  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     SETTLE_CYCLES  = 48;  // divider plus margin
  localparam longint SMP_MAX        = 8388607;
  localparam longint SMP_MIN        = -8388608;
  localparam logic [orsa_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum int {STY_CLEAN, STY_NOISY, STY_FAILING} stim_style_t;

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic [23:0]                      in_tdata   = '0;
  logic [0:0]                       in_tuser   = '0;
  logic                             out_tready = 1'b0;
  logic                             cfg_valid  = 1'b0;
  logic [orsa_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [orsa_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                             in_tready;
  logic                             out_tvalid;
  logic [23:0]                      out_tdata;
  logic [orsa_pkg::STATUS_W-1:0]    out_tuser;
  logic                             cfg_ready;

  avg_scoreboard sb;
  bit  calm;
  bit  hold_req;
  bit  hold_taken;
  int  hold_left, stall_left, quiet_cycles, words_sent, n_settings;

  outlier_rejecting_sample_average_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result receiver: random stall bursts plus one long hold on request
  always @(negedge clk) begin
    logic rdy;
    if (hold_req && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_tready <= rdy;
  end

  // Handshake monitor feeding the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (cfg_valid && cfg_ready)   sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready)   sb.note_word(in_tdata, in_tuser[0]);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Next sample word, shaped around the current reference sample
  function automatic logic [24:0] pick_word(stim_style_t sty);
    longint      base, span, cand, step;
    int          roll, t_near, t_stuck, t_out, t_tmo;
    logic [23:0] junk;
    junk = 24'($urandom());
    roll = $urandom_range(0, 99);
    base = sb.have_ref ? sb.last_good : longint'($signed(junk));
    span = longint'(sb.dev_reg);
    case (sty)
      STY_CLEAN: begin
        t_near = 82; t_stuck = 88; t_out = 94; t_tmo = 96;
      end
      STY_NOISY: begin
        t_near = 35; t_stuck = 55; t_out = 75; t_tmo = 80;
      end
      default: begin
        t_near = 8; t_stuck = 60; t_out = 100; t_tmo = 100;
      end
    endcase
    if (roll < t_near) begin
      cand = base + longint'($urandom_range(0, 32'(2 * span))) - span;
      if (cand > SMP_MAX) cand = SMP_MAX;
      if (cand < SMP_MIN) cand = SMP_MIN;
    end else if (roll < t_stuck) begin
      cand = $urandom_range(0, 1) ? 0 : -1;
    end else if (roll < t_out) begin
      // just past the limit on either side, random if neither fits
      step = span + 1 + longint'($urandom_range(0, 1000));
      cand = $urandom_range(0, 1) ? base + step : base - step;
      if (cand > SMP_MAX) cand = base - step;
      if (cand < SMP_MIN) cand = base + step;
      if (cand > SMP_MAX) cand = longint'($signed(junk));
    end else if (roll < t_tmo) begin
      return {1'b1, junk};
    end else begin
      cand = longint'($signed(junk));
    end
    return {1'b0, cand[23:0]};
  endfunction

  // Offer one word, with an optional idle burst ahead of it
  task automatic send_word(input logic [23:0] smp, input logic tmo);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= tmo;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Stop offering and wait until every expected result is out
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [orsa_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [orsa_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // All three registers, with junk in the unused upper bits
  task automatic set_regs(input logic [15:0] cnt, input logic [23:0] dev,
                          input logic [7:0] flim);
    drain();
    write_reg(orsa_pkg::REG_SAMPLE_COUNT, {8'($urandom()), cnt});
    write_reg(orsa_pkg::REG_DEVIATION_LIMIT, dev);
    write_reg(orsa_pkg::REG_FAILURE_LIMIT, {16'($urandom()), flim});
    n_settings++;
  endtask

  initial begin
    logic [15:0] cnt;
    logic [23:0] dev;
    logic [7:0]  flim;
    logic [24:0] w;
    stim_style_t sty;
    int          n_phase, n_items, r;

    sb = new;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: timeout straight out of reset
    send_word(24'($urandom()), 1'b1);
    // zero count: the discarded first sample ends the run
    set_regs(16'd0, orsa_pkg::DEVIATION_LIMIT_RST, orsa_pkg::FAILURE_LIMIT_RST);
    send_word(24'h7FFFFF, 1'b0);
    // widest limit, single failure aborts, unmapped index ignored
    set_regs(16'd2, 24'hFFFFFF, 8'd1);
    write_reg(REG_UNMAPPED, 24'($urandom()));
    send_word(24'h800000, 1'b0);
    send_word(24'h7FFFFF, 1'b0);
    send_word(24'h800000, 1'b0);
    send_word(24'hFFFFFF, 1'b0);
    repeat (3) send_word(24'h7FFFFF, 1'b0);
    repeat (3) send_word(24'h800000, 1'b0);
    // zero deviation and zero failure limit
    set_regs(16'd3, 24'd0, 8'd0);
    send_word(24'd5, 1'b0);
    send_word(24'd100, 1'b0);
    send_word(24'd101, 1'b0);
    // stuck code and outlier below the failure limit
    set_regs(16'd2, 24'd10, 8'd3);
    send_word(24'd7, 1'b0);
    send_word(24'd50, 1'b0);
    send_word(24'd0, 1'b0);
    send_word(24'd61, 1'b0);
    send_word(24'd40, 1'b0);
    // largest count, then lowered mid-run
    set_regs(16'hFFFF, 24'hFFFFFF, 8'd255);
    send_word(24'd9, 1'b0);
    send_word(-24'sd5, 1'b0);
    send_word(-24'sd6, 1'b0);
    drain();
    write_reg(orsa_pkg::REG_SAMPLE_COUNT, 24'd1);
    send_word(24'd4, 1'b0);

    // Random phases
    n_phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      r = $urandom_range(0, 9);
      cnt = (r < 6) ? 16'($urandom_range(0, 4)) :
            (r < 9) ? 16'($urandom_range(5, 24)) : 16'($urandom_range(25, 60));
      r = $urandom_range(0, 9);
      case (r)
        0:       dev = 24'd0;
        1:       dev = 24'($urandom_range(1, 64));
        2, 3, 4: dev = 24'($urandom_range(100, 5000));
        5, 6:    dev = 24'($urandom_range(5000, 400000));
        7:       dev = 24'hFFFFFF;
        default: dev = 24'($urandom());
      endcase
      r = $urandom_range(0, 9);
      flim = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'd255 :
             8'($urandom_range(2, 12));
      sty = ($urandom_range(0, 3) == 0) ? STY_NOISY : STY_CLEAN;
      n_items = $urandom_range(60, 150);
      // short runs while the receiver holds off
      if (n_phase == 1) begin
        cnt = 16'd1;
        sty = STY_CLEAN;
      end
      // long failure streak up to the top failure limit
      if (n_phase == 3) begin
        cnt     = 16'hFFFF;
        flim    = 8'd255;
        sty     = STY_FAILING;
        n_items = 300;
      end
      set_regs(cnt, dev, flim);
      calm = (words_sent > TOTAL_WORDS - 250) || ($urandom_range(0, 3) == 0);
      if (n_phase == 1) hold_req = 1'b1;
      repeat (n_items) begin
        w = pick_word(sty);
        send_word(w[23:0], w[24]);
        if ($urandom_range(0, 59) == 0) drain();
      end
      n_phase++;
    end

    // Wind down
    drain();
    $display("%0d sample words (%0d timed out) under %0d register settings",
             sb.n_words, sb.n_timed_out, n_settings);
    $display("%0d averages, %0d timeout aborts, %0d failure aborts, %0d mismatches",
             sb.n_done, sb.n_timeouts, sb.n_overfail, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
